[hw/rtl/csvp_pkg.sv]
// csvp_pkg: shared types and constants of the CSV integer series parser.
// Used by csvp_front, csvp_emit and csv_int_series_parser; depends on nothing.

package csvp_pkg;

  localparam int CountBits = 7;

  localparam logic [CountBits-1:0] MaxCountReset = 7'd24;

  // ASCII codes
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChSpace = 8'h20;  // ' '
  localparam logic [7:0] ChMinus = 8'h2D;  // '-'
  localparam logic [7:0] ChNul   = 8'h00;  // terminator

  localparam int Radix = 10;

  // Per-entry flags carried from front to back through the queue
  typedef struct packed {
    logic has_num;   // entry carries a parsed number
    logic has_sum;   // entry carries the end-of-buffer summary
    logic term;      // terminator seen within the buffer
  } flags_t;

  localparam int FlagBits = $bits(flags_t);

  // Output kinds (tuser)
  localparam logic KindNumber  = 1'b0;
  localparam logic KindSummary = 1'b1;

endpackage

[hw/rtl/csvp_queue.sv]
// csvp_queue: small flop-based FIFO between parser front and beat emitter.
// Depends on nothing.

module csvp_queue #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full     = (fill == (AW+1)'(DEPTH));
  assign nonempty = (fill != '0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/csvp_front.sv]
// csvp_front: byte classifier and token state machine; builds queue entries.
// Depends on csvp_pkg.

module csvp_front #(
  parameter int VALUE_BITS  = 32,
  parameter int COUNT_LIMIT = 64
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [csvp_pkg::CountBits-1:0]            cfg_data,
  input  logic                                      accept,
  input  logic [7:0]                                text_byte,
  input  logic                                      buffer_end,
  output logic                                      push,
  output logic [VALUE_BITS-1:0]                     number,
  output logic [csvp_pkg::CountBits-1:0]            total,
  output csvp_pkg::flags_t                          flags
);

  localparam int MW = VALUE_BITS - 1;  // magnitude width
  localparam int PW = VALUE_BITS + 3;  // acc*10+d fits here
  localparam logic [PW-1:0] MaxMag = PW'({MW{1'b1}});

  typedef enum logic [2:0] {
    PH_IDLE, PH_SIGN, PH_DIGITS, PH_BADSKIP, PH_TAILSKIP
  } phase_t;

  phase_t                          phase, phase_next;
  logic [MW-1:0]                   acc, acc_next;
  logic                            negative, negative_next;
  logic [csvp_pkg::CountBits-1:0]  count, count_next;
  logic                            term_seen, term_seen_next;
  logic [csvp_pkg::CountBits-1:0]  max_count;
  logic [csvp_pkg::CountBits-1:0]  limit;

  logic          is_digit, is_sep, emit, below;
  logic [3:0]    dval;
  logic [PW-1:0] prod;
  logic [MW-1:0] acc_grown;

  assign limit = (max_count > csvp_pkg::CountBits'(COUNT_LIMIT))
               ? csvp_pkg::CountBits'(COUNT_LIMIT) : max_count;
  assign below    = (count < limit);
  assign is_digit = (text_byte >= csvp_pkg::ChZero) && (text_byte <= csvp_pkg::ChNine);
  assign is_sep   = (text_byte == csvp_pkg::ChComma) || (text_byte == csvp_pkg::ChSpace);
  assign dval     = 4'(text_byte - csvp_pkg::ChZero);

  // acc*10 + d as two shifts and adds; saturate at the largest magnitude
  assign prod = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(dval);
  assign acc_grown = (prod > MaxMag) ? MaxMag[MW-1:0] : prod[MW-1:0];

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    negative_next  = negative;
    count_next     = count;
    term_seen_next = term_seen;
    emit           = 1'b0;

    if (!term_seen) begin
      if (text_byte == csvp_pkg::ChNul) begin
        term_seen_next = 1'b1;
        emit           = below && (phase == PH_DIGITS);
        phase_next     = PH_IDLE;
      end else if (below) begin
        case (phase)
          PH_IDLE: begin
            if (is_sep) begin
              phase_next = PH_IDLE;
            end else if (text_byte == csvp_pkg::ChMinus) begin
              negative_next = 1'b1;
              phase_next    = PH_SIGN;
            end else if (is_digit) begin
              negative_next = 1'b0;
              acc_next      = MW'(dval);
              phase_next    = PH_DIGITS;
            end else begin
              phase_next = PH_BADSKIP;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              acc_next   = MW'(dval);
              phase_next = PH_DIGITS;
            end else begin
              phase_next = (text_byte == csvp_pkg::ChComma) ? PH_IDLE : PH_BADSKIP;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_next = acc_grown;
            end else begin
              emit       = 1'b1;
              phase_next = is_sep ? PH_IDLE : PH_TAILSKIP;
            end
          end
          PH_BADSKIP: begin
            if (text_byte == csvp_pkg::ChComma) begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
            if (is_sep) begin
              phase_next = PH_IDLE;
            end
          end
        endcase
      end
    end

    if (emit) begin
      count_next = count + 1'b1;
    end
  end

  // Queue entry for this byte
  assign push          = accept && (emit || buffer_end);
  assign number        = negative ? -VALUE_BITS'(acc) : VALUE_BITS'(acc);
  assign total         = count_next;
  assign flags.has_num = emit;
  assign flags.has_sum = buffer_end;
  assign flags.term    = term_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      acc       <= '0;
      negative  <= 1'b0;
      count     <= '0;
      term_seen <= 1'b0;
      max_count <= csvp_pkg::MaxCountReset;
    end else begin
      if (cfg_we) begin
        max_count <= cfg_data;
      end
      if (accept) begin
        if (buffer_end) begin
          // buffer done: back to the cleared state
          phase     <= PH_IDLE;
          acc       <= '0;
          negative  <= 1'b0;
          count     <= '0;
          term_seen <= 1'b0;
        end else begin
          phase     <= phase_next;
          acc       <= acc_next;
          negative  <= negative_next;
          count     <= count_next;
          term_seen <= term_seen_next;
        end
      end
    end
  end

endmodule

[hw/rtl/csvp_emit.sv]
// csvp_emit: turns queue entries into output beats (number, then summary).
// Depends on csvp_pkg.

module csvp_emit #(
  parameter int VALUE_BITS = 32,
  parameter int OUT_W      = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             nonempty,
  input  logic [VALUE_BITS-1:0]            number,
  input  logic [csvp_pkg::CountBits-1:0]   total,
  input  csvp_pkg::flags_t                 flags,
  output logic                             pop,
  output logic                             m_valid,
  input  logic                             m_ready,
  output logic [OUT_W-1:0]                 m_data,
  output logic                             m_kind,
  output logic                             m_last
);

  logic                           num_sent;  // number beat of head entry already out
  logic                           load;
  logic                           take_num;
  logic [VALUE_BITS-1:0]          out_number;
  logic [csvp_pkg::CountBits-1:0] out_total;
  logic                           out_valid_res;

  assign load     = nonempty && (!m_valid || m_ready);
  assign take_num = flags.has_num && !num_sent;
  assign pop      = load && !(take_num && flags.has_sum);

  assign m_data = OUT_W'({out_valid_res, out_total, out_number});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      num_sent <= 1'b0;
    end else if (load) begin
      m_valid  <= 1'b1;
      num_sent <= take_num && flags.has_sum;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_total <= total;
      if (take_num) begin
        m_kind        <= csvp_pkg::KindNumber;
        out_number    <= number;
        out_valid_res <= 1'b0;
        m_last        <= !flags.has_sum;
      end else begin
        m_kind        <= csvp_pkg::KindSummary;
        out_number    <= '0;
        out_valid_res <= flags.term;
        m_last        <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/csv_int_series_parser.sv]
// csv_int_series_parser: top level of the comma/space separated integer parser.
// Depends on csvp_pkg, csvp_front, csvp_queue and csvp_emit.

// Takes one text byte per beat (tlast on the final byte of the buffer) and
// emits a beat for each signed decimal number when its digit run ends, plus a
// summary beat (tuser = 1) on the buffer's final byte carrying the count and
// whether a NUL terminator lay inside the buffer; if it did not, discard the
// numbers of that buffer. The input side takes one byte per clock while the
// queue has room; the parser front updates its token state and accumulator
// (x10 as shift-and-add, with saturation) on each accepted byte. The output
// side gives one beat per clock while m_axis_tready is high. A final byte
// that also closes a number makes two beats, so a short queue (QUEUE_DEPTH
// entries, one per byte that produces output) sits between the front and
// the beat emitter; s_axis_tready drops only when that queue is full, i.e.
// when the output side is stalled. The user must write max_count through
// cfg_we/cfg_data only while the block is idle (not enforced); the
// effective limit is max_count capped at COUNT_LIMIT. Reset value of max_count is 24.

module csv_int_series_parser #(
  parameter int VALUE_BITS  = 32,
  parameter int COUNT_LIMIT = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // configuration
  input  logic                                      cfg_we,
  input  logic [csvp_pkg::CountBits-1:0]            cfg_data,   // max_count
  // byte input
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  logic [7:0]                                s_axis_tdata,  // [7:0] text_byte
  input  logic                                      s_axis_tlast,  // buffer_end
  // result output
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // from bit 0: number (VALUE_BITS), total (7), valid_res (1), zero fill to bytes
  output logic [((VALUE_BITS+8+7)/8)*8-1:0]         m_axis_tdata,
  output logic                                      m_axis_tuser,  // kind
  output logic                                      m_axis_tlast   // run_end
);

  localparam int OutW   = ((VALUE_BITS + 8 + 7) / 8) * 8;
  localparam int EntryW = VALUE_BITS + csvp_pkg::CountBits + csvp_pkg::FlagBits;

  logic                           accept;
  logic                           push;
  logic                           q_full;
  logic                           q_nonempty;
  logic                           pop;
  logic [VALUE_BITS-1:0]          f_number;
  logic [csvp_pkg::CountBits-1:0] f_total;
  csvp_pkg::flags_t               f_flags;
  logic [EntryW-1:0]              q_wdata;
  logic [EntryW-1:0]              q_rdata;
  logic [VALUE_BITS-1:0]          h_number;
  logic [csvp_pkg::CountBits-1:0] h_total;
  csvp_pkg::flags_t               h_flags;

  // each byte needs at most one queue entry, so room for one is enough
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  csvp_front #(
    .VALUE_BITS  (VALUE_BITS),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .text_byte  (s_axis_tdata),
    .buffer_end (s_axis_tlast),
    .push       (push),
    .number     (f_number),
    .total      (f_total),
    .flags      (f_flags)
  );

  assign q_wdata = {f_number, f_total, f_flags};

  csvp_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  assign {h_number, h_total, h_flags} = q_rdata;

  csvp_emit #(
    .VALUE_BITS (VALUE_BITS),
    .OUT_W      (OutW)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .nonempty (q_nonempty),
    .number   (h_number),
    .total    (h_total),
    .flags    (h_flags),
    .pop      (pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_data   (m_axis_tdata),
    .m_kind   (m_axis_tuser),
    .m_last   (m_axis_tlast)
  );

endmodule

[verif/csv_int_series_parser_tb.sv]
// Self-checking testbench for csv_int_series_parser: text buffers in, numbers and summaries out.
// Depends on csvp_pkg and the csv_int_series_parser RTL. A class tracks the parser state and
// keeps the result beats it predicts.

typedef struct packed {
  logic        kind;
  logic [31:0] number;
  logic [6:0]  total;
  logic        valid_res;
  logic        run_end;
} result_beat_t;

typedef enum logic [2:0] {TOK_GAP, TOK_SIGN, TOK_DIGITS, TOK_JUNK, TOK_TAIL} token_state_t;

class number_list_tracker;
  localparam int CountCap = 64;
  localparam logic [63:0] MagMax = 64'h7FFF_FFFF;

  int           max_count;
  token_state_t tok;
  logic [63:0]  mag;
  bit           neg;
  int           count;
  bit           nul_seen;
  int           errors;
  result_beat_t pending_results[$];

  function new();
    max_count = csvp_pkg::MaxCountReset;
    errors = 0;
    clear_buffer();
  endfunction

  function void clear_buffer();
    tok = TOK_GAP;
    mag = '0;
    neg = 1'b0;
    count = 0;
    nul_seen = 1'b0;
  endfunction

  function void set_max_count(int v);
    max_count = v;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void queue_result(logic kind, logic [31:0] num, logic valid);
    result_beat_t r;
    r.kind = kind;
    r.number = num;
    r.total = count[6:0];
    r.valid_res = valid;
    r.run_end = 1'b0;
    pending_results.push_back(r);
  endfunction

  function void close_number();
    logic [31:0] v;
    v = mag[31:0];
    if (neg) v = -v;
    count++;
    queue_result(csvp_pkg::KindNumber, v, 1'b0);
  endfunction

  // Advances the parser by one byte and queues the beats it causes.
  function void predict_byte(logic [7:0] b, logic last);
    int lim;
    int before_n;
    bit dig;
    logic [63:0] d;
    lim = (max_count > CountCap) ? CountCap : max_count;
    dig = (b >= csvp_pkg::ChZero) && (b <= csvp_pkg::ChNine);
    d = 64'(b - csvp_pkg::ChZero);
    before_n = pending_results.size();
    if (!nul_seen) begin
      if (b == csvp_pkg::ChNul) begin
        nul_seen = 1'b1;
        if (count < lim && tok == TOK_DIGITS) close_number();
        tok = TOK_GAP;
      end else if (count < lim) begin
        case (tok)
          TOK_GAP: begin
            if (b == csvp_pkg::ChSpace || b == csvp_pkg::ChComma) begin
              // still between tokens
            end else if (b == csvp_pkg::ChMinus) begin
              neg = 1'b1;
              tok = TOK_SIGN;
            end else if (dig) begin
              neg = 1'b0;
              mag = d;
              tok = TOK_DIGITS;
            end else begin
              tok = TOK_JUNK;
            end
          end
          TOK_SIGN: begin
            if (dig) begin
              mag = d;
              tok = TOK_DIGITS;
            end else begin
              tok = (b == csvp_pkg::ChComma) ? TOK_GAP : TOK_JUNK;
            end
          end
          TOK_DIGITS: begin
            if (dig) begin
              // saturate the magnitude at 2^31-1
              if (mag > (MagMax - d) / csvp_pkg::Radix) mag = MagMax;
              else mag = mag * csvp_pkg::Radix + d;
            end else begin
              close_number();
              tok = (b == csvp_pkg::ChComma || b == csvp_pkg::ChSpace) ? TOK_GAP : TOK_TAIL;
            end
          end
          TOK_JUNK: begin
            if (b == csvp_pkg::ChComma) tok = TOK_GAP;
          end
          default: begin
            if (b == csvp_pkg::ChComma || b == csvp_pkg::ChSpace) tok = TOK_GAP;
          end
        endcase
      end
    end
    if (last) begin
      queue_result(csvp_pkg::KindSummary, '0, nul_seen);
      clear_buffer();
    end
    if (pending_results.size() > before_n)
      pending_results[pending_results.size()-1].run_end = 1'b1;
  endfunction

  function void match_beat(result_beat_t got);
    result_beat_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected beat, expected none, got %h", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind) begin
      $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.number !== want.number) begin
      $display("%0t: number expected %0d got %0d", $time,
               $signed(want.number), $signed(got.number));
      errors++;
    end
    if (got.total !== want.total) begin
      $display("%0t: total expected %0d got %0d", $time, want.total, got.total);
      errors++;
    end
    if (got.valid_res !== want.valid_res) begin
      $display("%0t: valid_res expected %0d got %0d", $time, want.valid_res, got.valid_res);
      errors++;
    end
    if (got.run_end !== want.run_end) begin
      $display("%0t: run_end expected %0d got %0d", $time, want.run_end, got.run_end);
      errors++;
    end
  endfunction
endclass

module csv_int_series_parser_tb;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  number_list_tracker tracker = new();

  logic [7:0] text_q[$];
  int         sent_bytes;
  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;

  csv_int_series_parser #(
    .VALUE_BITS (32),
    .COUNT_LIMIT(64)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly zero or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 87) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // One random buffer: mostly numbers and separators, some junk, usually a NUL.
  function automatic void fill_buffer();
    int target;
    int r;
    int nd;
    string lit;
    text_q.delete();
    target = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
    while (text_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        case ($urandom_range(0, 2))
          0: lit = "2147483647";
          1: lit = "2147483648";
          default: lit = "-2147483647";
        endcase
        for (int i = 0; i < lit.len(); i++) text_q.push_back(lit[i]);
      end else if (r < 66) begin
        if ($urandom_range(0, 2) == 0) text_q.push_back(csvp_pkg::ChMinus);
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
        repeat (nd) text_q.push_back(8'(csvp_pkg::ChZero + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
      end else if (r < 76) begin
        text_q.push_back(csvp_pkg::ChMinus);
        if ($urandom_range(0, 1) == 1) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 7))
        0, 1, 2: text_q.push_back(csvp_pkg::ChComma);
        3, 4: text_q.push_back(csvp_pkg::ChSpace);
        5: begin
          text_q.push_back(csvp_pkg::ChComma);
          text_q.push_back(csvp_pkg::ChSpace);
        end
        6: begin
          text_q.push_back(csvp_pkg::ChSpace);
          text_q.push_back(csvp_pkg::ChSpace);
        end
        default: ;
      endcase
    end
    if ($urandom_range(0, 5) != 0) text_q.push_back(csvp_pkg::ChNul);
    repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic push_byte(logic [7:0] b, logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.predict_byte(b, last);
    sent_bytes++;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_text(string s, logic last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], last && (i == s.len() - 1));
  endtask

  // sender stops and waits for every predicted beat, then lets the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_count(int v);
    cfg_we   <= 1'b1;
    cfg_data <= 7'(v);
    @(posedge clk);
    cfg_we   <= 1'b0;
    tracker.set_max_count(v);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    logic rdy;
    result_beat_t got;
    stall_left = 0;
    hold_left = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (stall_left > 0 && !no_idle) begin
        rdy = 1'b0;
        stall_left--;
      end else begin
        rdy = 1'b1;
        stall_left = no_idle ? 0 : idle_len();
      end
      m_axis_tready <= rdy;
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        got.kind      = m_axis_tuser;
        got.number    = m_axis_tdata[31:0];
        got.total     = m_axis_tdata[38:32];
        got.valid_res = m_axis_tdata[39];
        got.run_end   = m_axis_tlast;
        tracker.match_beat(got);
      end
    end
  end

  initial begin
    int cfg_plan[6];
    cfg_plan[0] = 1;
    cfg_plan[1] = 64;
    cfg_plan[2] = $urandom_range(2, 63);
    cfg_plan[3] = 2;
    cfg_plan[4] = 64;
    cfg_plan[5] = $urandom_range(1, 64);
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    sent_bytes    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed, reset limit: saturation, junk token, lone sign, tail junk, zero,
    // bytes after the NUL, then a digit run cut off with no terminator
    push_text("-99999999999 a,-,7z 0", 1'b0);
    push_byte(csvp_pkg::ChNul, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_text("5", 1'b1);

    for (int p = 0; p < 6; p++) begin
      drain();
      write_max_count(cfg_plan[p]);
      no_idle = (p == 4);
      if (p == 2) hold_req = 1'b1;
      sent_bytes = 0;
      while (sent_bytes < 95) begin
        fill_buffer();
        foreach (text_q[i]) push_byte(text_q[i], i == text_q.size() - 1);
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
